@@ hdl/esc_telemetry_frame_parser_defines.svh @@
// Assertion macros shared by the frame parser RTL.
// Each check is clocked on clk and held off while rst is high.
`ifndef ESC_TELEMETRY_FRAME_PARSER_DEFINES_SVH
`define ESC_TELEMETRY_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication: when cond holds, cons must hold too.
`define ETFP_CHECK_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when cond holds, cons must hold in the following cycle.
`define ETFP_CHECK_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/etfp_pkg.sv @@
package etfp_pkg;

  // Frame layout: nine covered bytes, then the CRC byte
  localparam int unsigned  CRC_LEN       = 9;
  localparam logic [3:0]   LAST_BYTE     = 4'd9;
  localparam logic [7:0]   CRC_POLY      = 8'h07;

  // Tick counter
  localparam logic [23:0]  TICK_MAX      = 24'hFF_FFFF;
  localparam logic [23:0]  TIMEOUT_RESET = 24'd100000;

  // Configuration port
  localparam int unsigned  APB_AW        = 3;
  localparam logic         REG_TIMEOUT   = 1'b0;

  // Input command codes
  localparam logic         CMD_BYTE      = 1'b0;
  localparam logic         CMD_TICK      = 1'b1;

  // Result kind codes
  localparam logic         KIND_FRAME    = 1'b0;
  localparam logic         KIND_TIMEOUT  = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic        crc_ok;
    logic [7:0]  temperature;
    logic [15:0] voltage;
    logic [15:0] current;
    logic [15:0] charge_used;
    logic [15:0] erpm;
  } out_t;

  // Byte-wide CRC-8 update, MSB first, no reflection
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    return v;
  endfunction

endpackage

@@ hdl/etfp_apb_regs.sv @@
module etfp_apb_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [etfp_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [23:0]                 timeout_ticks
);
  import etfp_pkg::*;

  logic wr_en;
  logic hit_timeout;

  // Decode the word index
  assign hit_timeout = (paddr[APB_AW-1] == REG_TIMEOUT);
  assign wr_en       = psel && penable && pwrite && pready;
  assign pready      = 1'b1;

  // Hold the timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (wr_en && hit_timeout) begin
      timeout_ticks <= pwdata[23:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (hit_timeout) begin
      prdata = {8'd0, timeout_ticks};
    end
  end

endmodule

@@ hdl/esc_telemetry_frame_parser.sv @@
// Path: the input register holds the accepted item, then the result register holds its result.
// Throughput: one item per cycle while item_stall is low; every item is handled in a single pass through the
// CRC byte update and field assembly between the two registers.
// Backpressure on the result side stalls the input only when an item has a result to give.
// Reset (rst, synchronous): no frame held, CRC cleared, tick counter all ones (expired),
// timeout_ticks back to 100000; the frame byte store is not cleared.
`include "esc_telemetry_frame_parser_defines.svh"

module esc_telemetry_frame_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  etfp_pkg::in_t               item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output etfp_pkg::out_t              result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [etfp_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import etfp_pkg::*;

  logic [23:0] timeout_ticks;

  // Input register
  logic        held_valid;
  in_t         held;

  // Frame state
  logic [3:0]  byte_count;
  logic [3:0]  byte_count_next;
  logic [7:0]  running_crc;
  logic [7:0]  running_crc_next;
  logic [23:0] elapsed_ticks;
  logic [23:0] elapsed_ticks_next;
  logic [7:0]  frame_bytes [CRC_LEN];

  // Single-pass decode
  logic        is_tick;
  logic        expire;
  logic        frame_end;
  logic        produce;
  logic        advance;
  logic        store_byte;
  out_t        result_next;

  etfp_apb_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .timeout_ticks (timeout_ticks)
  );

  // Classify the held item
  assign is_tick    = (held.cmd == CMD_TICK);
  assign expire     = (elapsed_ticks > timeout_ticks) && (byte_count != 4'd0);
  assign frame_end  = !is_tick && (byte_count == LAST_BYTE);
  assign store_byte = !is_tick && !frame_end;
  assign produce    = (is_tick && expire) || frame_end;

  // Advance unless a result is due and the result register is blocked
  assign advance    = held_valid && (!produce || !result_valid || !result_stall);
  assign item_stall = held_valid && !advance;

  // Next frame state
  always_comb begin
    byte_count_next    = byte_count;
    running_crc_next   = running_crc;
    elapsed_ticks_next = elapsed_ticks;
    if (is_tick) begin
      if (expire) begin
        byte_count_next    = 4'd0;
        running_crc_next   = 8'd0;
        elapsed_ticks_next = 24'd0;
      end else if (elapsed_ticks != TICK_MAX) begin
        elapsed_ticks_next = elapsed_ticks + 24'd1;
      end
    end else if (frame_end) begin
      byte_count_next    = 4'd0;
      running_crc_next   = 8'd0;
      elapsed_ticks_next = 24'd0;
    end else begin
      byte_count_next    = byte_count + 4'd1;
      running_crc_next   = crc8_step(running_crc, held.data_byte);
    end
  end

  // Assemble the result; a timeout reports zeros
  always_comb begin
    result_next = '0;
    if (frame_end) begin
      result_next.kind        = KIND_FRAME;
      result_next.crc_ok      = (running_crc == held.data_byte);
      result_next.temperature = frame_bytes[0];
      result_next.voltage     = {frame_bytes[1], frame_bytes[2]};
      result_next.current     = {frame_bytes[3], frame_bytes[4]};
      result_next.charge_used = {frame_bytes[5], frame_bytes[6]};
      result_next.erpm        = {frame_bytes[7], frame_bytes[8]};
    end else begin
      result_next.kind        = KIND_TIMEOUT;
    end
  end

  // Load the input register when it is empty or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held <= item;
    end
  end

  // Update frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= 4'd0;
      running_crc   <= 8'd0;
      elapsed_ticks <= TICK_MAX;
    end else if (advance) begin
      byte_count    <= byte_count_next;
      running_crc   <= running_crc_next;
      elapsed_ticks <= elapsed_ticks_next;
    end
  end

  // Store covered frame bytes
  always_ff @(posedge clk) begin
    if (advance && store_byte) begin
      frame_bytes[byte_count] <= held.data_byte;
    end
  end

  // Result register: fill on a produced item, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && produce) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      result <= result_next;
    end
  end

  `ETFP_CHECK_NEXT(a_result_clears_frame, advance && produce, byte_count == 4'd0 && running_crc == 8'd0, "frame state not cleared after a result")
  `ETFP_CHECK_NEXT(a_result_restarts_ticks, advance && produce, elapsed_ticks == 24'd0, "tick counter not restarted after a result")
  `ETFP_CHECK_NOW(a_stall_only_on_backpressure, item_stall, result_valid && result_stall && produce, "input stalled without result backpressure")
  `ETFP_CHECK_NOW(a_timeout_fields_zero, result_valid && result.kind == KIND_TIMEOUT, !result.crc_ok && result.temperature == 8'd0 && result.erpm == 16'd0, "timeout result carries frame data")
  `ETFP_CHECK_NOW(a_count_in_range, held_valid, byte_count <= LAST_BYTE, "byte count beyond frame length")

endmodule
